/* sv/uvs_pkg.sv */
// ----------------------------------------------------------------------------
// uvs_pkg: shared types, constants and tables for the UV sphere vertex block
// Holds the arctangent table, fixed-point constants and the pipeline beat type.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_LON_LEVEL_DEF = 6;
  localparam int ATAN_ENTRIES      = 24;

  // configuration register indexes
  localparam logic [1:0] REG_LAT    = 2'd0;
  localparam logic [1:0] REG_LON    = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // arctangent of 2^-k in binary angle units (2^32 = one turn)
  function automatic logic signed [33:0] atan_turn(input int k);
    logic signed [33:0] t;
    begin
      case (k)
        0:  t = 34'sd536870912;
        1:  t = 34'sd316933406;
        2:  t = 34'sd167458907;
        3:  t = 34'sd85004756;
        4:  t = 34'sd42667331;
        5:  t = 34'sd21354465;
        6:  t = 34'sd10679838;
        7:  t = 34'sd5340245;
        8:  t = 34'sd2670163;
        9:  t = 34'sd1335087;
        10: t = 34'sd667544;
        11: t = 34'sd333772;
        12: t = 34'sd166886;
        13: t = 34'sd83443;
        14: t = 34'sd41722;
        15: t = 34'sd20861;
        16: t = 34'sd10430;
        17: t = 34'sd5215;
        18: t = 34'sd2608;
        19: t = 34'sd1304;
        20: t = 34'sd652;
        21: t = 34'sd326;
        22: t = 34'sd163;
        23: t = 34'sd81;
        default: t = 34'sd0;
      endcase
      return t;
    end
  endfunction

  // vertex kind carried through the pipeline
  typedef enum logic [3:0] {
    KIND_RING  = 4'b0001,
    KIND_NORTH = 4'b0010,
    KIND_SOUTH = 4'b0100,
    KIND_OOR   = 4'b1000
  } kind_t;

  // side data that rides along the rotation cells
  typedef struct packed {
    logic        vld;
    kind_t       kind;
    logic        flip_t;
    logic        flip_p;
    logic [15:0] radius;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [13:0] addr;
  } side_t;

  // one CORDIC lane state
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } rot_t;

endpackage

/* sv/uvs_cell.sv */
// ----------------------------------------------------------------------------
// uvs_cell: one CORDIC rotation cell, two lanes (polar and azimuth)
// Each cell applies micro-rotation STAGE and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module uvs_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  uvs_pkg::rot_t  t_in,
  input  uvs_pkg::rot_t  p_in,
  input  uvs_pkg::side_t s_in,
  output uvs_pkg::rot_t  t_out,
  output uvs_pkg::rot_t  p_out,
  output uvs_pkg::side_t s_out
);

  localparam logic signed [33:0] ANG = uvs_pkg::atan_turn(STAGE);

  function automatic uvs_pkg::rot_t rotate(input uvs_pkg::rot_t a);
    uvs_pkg::rot_t      r;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    begin
      dx = a.y >>> STAGE;
      dy = a.x >>> STAGE;
      if (!a.z[33]) begin
        r.x = a.x - dx; r.y = a.y + dy; r.z = a.z - ANG;
      end else begin
        r.x = a.x + dx; r.y = a.y - dy; r.z = a.z + ANG;
      end
      return r;
    end
  endfunction

  // data registers
  always_ff @(posedge clk) begin
    t_out <= rotate(t_in);
    p_out <= rotate(p_in);
    if (rst) begin
      s_out <= '0;
    end else begin
      s_out <= s_in;
    end
  end

endmodule

/* sv/uvs_front.sv */
// ----------------------------------------------------------------------------
// uvs_front: grid decode and angle setup
// Clamps levels, checks range, forms angles, texture and address; one register.
// ----------------------------------------------------------------------------
module uvs_front #(
  parameter int MAX_LON_LEVEL = uvs_pkg::MAX_LON_LEVEL_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  logic [6:0]     grid_row,
  input  logic [6:0]     grid_col,
  input  logic [2:0]     lat_cfg,
  input  logic [2:0]     lon_cfg,
  input  logic [15:0]    sphere_radius,
  output uvs_pkg::rot_t  t_out,
  output uvs_pkg::rot_t  p_out,
  output uvs_pkg::side_t s_out
);

  // floor(2^32 / 3)
  localparam logic [31:0] THIRD = 32'h5555_5555;

  logic [2:0]      lat;
  logic [3:0]      lonp1;
  logic [7:0]      rings1;
  logic [8:0]      cols;
  logic [31:0]     theta;
  logic [31:0]     phi;
  logic [13:0]     row_prod;
  logic [6:0]      row_q;
  logic [6:0]      row_m3;
  logic [1:0]      row_rem;
  logic [31:0]     theta_base;
  logic [31:0]     theta_frac;
  logic [15:0]     tex_v;
  logic [13:0]     addr;
  logic [13:0]     addr_prod;
  logic [15:0]     tex_u;
  uvs_pkg::kind_t  kind;
  logic            oor;

  // table of round(i*32768/(R+1)) for each level would be large; divide by
  // 3*2^(L-1): v = (i*65536 + den) / (2*den), den = 3*2^(L-1)
  // -> floor((i*2^(17-L) + 3) / 6) ... computed with a reciprocal of 3
  logic [23:0] v_num;
  logic [47:0] v_prod;
  logic [23:0] v_q;

  function automatic logic signed [33:0] fold(input logic [31:0] a);
    logic [31:0] b;
    begin
      b = (a[31] ^ a[30]) ? a - 32'h8000_0000 : a;
      return {{2{b[31]}}, b};
    end
  endfunction

  always_comb begin
    lat    = (lat_cfg == 3'd0) ? 3'd1 : ((lat_cfg == 3'd7) ? 3'd6 : lat_cfg);
    lonp1  = ({1'b0, lon_cfg} > 4'(MAX_LON_LEVEL)) ? 4'(MAX_LON_LEVEL + 1) :
             {1'b0, lon_cfg} + 4'd1;
    rings1 = 8'(8'd3 << (lat - 3'd1));
    cols   = 9'd1 << lonp1;
    oor    = ({1'b0, grid_row} > rings1) || ({2'b0, grid_col} >= cols);
    // polar angle (row*2^(32-L) + 1)/3: row = 3q + rem, q*2^(32-L) exact,
    // rem part from floor(2^32/3) shifted, plus one when 2^k is 2 mod 3
    row_prod = {7'd0, grid_row} * 14'd43;
    row_q    = row_prod[13:7];
    row_m3   = row_q * 7'd3;
    row_rem  = 2'(grid_row - row_m3);
    theta_base = {25'd0, row_q} << (6'd32 - {3'd0, lat});
    case (row_rem)
      2'd1:    theta_frac = (THIRD >> lat) + {31'd0, lat[0]};
      2'd2:    theta_frac = (THIRD >> (lat - 3'd1)) + {31'd0, ~lat[0]};
      default: theta_frac = '0;
    endcase
    theta      = theta_base + theta_frac;
    phi        = 32'(({25'd0, grid_col} + 32'd1) << (6'd32 - {2'd0, lonp1}));
    tex_u      = 16'((({17'd0, grid_col} + 24'd1) << 15) >> lonp1);
    addr_prod  = 14'(({7'd0, grid_row} << lonp1) + {7'd0, grid_col});
    addr       = addr_prod;
    // v = floor((i*2^(17-L) + 3) / 6)
    v_num  = 24'(({17'd0, grid_row} << (5'd17 - {2'd0, lat})) + 24'd3);
    v_prod = 48'({24'd0, v_num} * 48'hAAAAAB);
    v_q    = v_prod[47:24] >> 2;
    tex_v  = v_q[15:0];
    if (oor) kind = uvs_pkg::KIND_OOR;
    else if (grid_row == 7'd0) kind = uvs_pkg::KIND_NORTH;
    else if ({1'b0, grid_row} == rings1) kind = uvs_pkg::KIND_SOUTH;
    else kind = uvs_pkg::KIND_RING;
  end

  always_ff @(posedge clk) begin
    t_out.x      <= uvs_pkg::CORDIC_GAIN_Q30;
    t_out.y      <= '0;
    t_out.z      <= fold(theta);
    p_out.x      <= uvs_pkg::CORDIC_GAIN_Q30;
    p_out.y      <= '0;
    p_out.z      <= fold(phi);
    s_out.vld    <= rst ? 1'b0 : go;
    s_out.kind   <= kind;
    s_out.flip_t <= theta[31] ^ theta[30];
    s_out.flip_p <= phi[31] ^ phi[30];
    s_out.radius <= sphere_radius;
    s_out.tex_u  <= tex_u;
    s_out.tex_v  <= tex_v;
    s_out.addr   <= addr;
  end

endmodule

/* sv/uvs_back.sv */
// ----------------------------------------------------------------------------
// uvs_back: products, rounding and saturation
// Three stages: sin*cos products, radius products, round/saturate/select.
// ----------------------------------------------------------------------------
module uvs_back (
  input  logic                clk,
  input  logic                rst,
  input  uvs_pkg::rot_t       t_in,
  input  uvs_pkg::rot_t       p_in,
  input  uvs_pkg::side_t      s_in,
  output logic                done,
  output logic signed [16:0]  pos_x,
  output logic signed [16:0]  pos_y,
  output logic signed [16:0]  pos_z,
  output logic signed [15:0]  norm_x,
  output logic signed [15:0]  norm_y,
  output logic signed [15:0]  norm_z,
  output logic [15:0]         tex_u,
  output logic [15:0]         tex_v,
  output logic [13:0]         vertex_address,
  output logic                out_of_range
);

  logic signed [33:0] st, ct, sp, cp;
  logic signed [67:0] pr_x, pr_z;
  logic signed [33:0] nx1, nz1, ct1;
  uvs_pkg::side_t     s1, s2;
  logic signed [33:0] nx2, nz2, ct2;
  logic signed [51:0] px2, py2, pz2;
  logic signed [16:0] pos_x_next, pos_y_next, pos_z_next;
  logic signed [15:0] norm_x_next, norm_y_next, norm_z_next;
  logic [15:0]        tex_u_next, tex_v_next;
  logic [13:0]        addr_next;
  logic               oor_next;

  function automatic logic signed [16:0] to_pos(input logic signed [51:0] v);
    logic signed [51:0] t;
    begin
      t = (v + 52'sd536870912) >>> 30;
      if (t > 52'sd65535) return 17'sd65535;
      if (t < -52'sd65535) return -17'sd65535;
      return t[16:0];
    end
  endfunction

  function automatic logic signed [15:0] to_norm(input logic signed [33:0] v);
    logic signed [33:0] t;
    begin
      t = (v + 34'sd32768) >>> 16;
      if (t > 34'sd16384) return 16'sd16384;
      if (t < -34'sd16384) return -16'sd16384;
      return t[15:0];
    end
  endfunction

  // quadrant unfold, then sin(theta)*cos/sin(phi)
  always_comb begin
    st = s_in.flip_t ? -t_in.y : t_in.y;
    ct = s_in.flip_t ? -t_in.x : t_in.x;
    sp = s_in.flip_p ? -p_in.y : p_in.y;
    cp = s_in.flip_p ? -p_in.x : p_in.x;
    pr_x = st * cp;
    pr_z = st * sp;
  end

  // final select by vertex kind
  always_comb begin
    pos_x_next  = '0;
    pos_y_next  = '0;
    pos_z_next  = '0;
    norm_x_next = '0;
    norm_y_next = '0;
    norm_z_next = '0;
    tex_u_next  = s2.tex_u;
    tex_v_next  = '0;
    addr_next   = s2.addr;
    oor_next    = 1'b0;
    case (s2.kind)
      uvs_pkg::KIND_RING: begin
        pos_x_next = to_pos(px2); pos_y_next = to_pos(py2); pos_z_next = to_pos(pz2);
        norm_x_next = to_norm(nx2); norm_y_next = to_norm(ct2);
        norm_z_next = to_norm(nz2);
        tex_v_next = s2.tex_v;
      end
      uvs_pkg::KIND_NORTH: begin
        pos_y_next = $signed({1'b0, s2.radius}); norm_y_next = 16'sd16384;
        tex_v_next = 16'd32768;
      end
      uvs_pkg::KIND_SOUTH: begin
        pos_y_next = -$signed({1'b0, s2.radius}); norm_y_next = -16'sd16384;
        tex_v_next = 16'd0;
      end
      default: begin
        tex_u_next = '0; addr_next = '0; oor_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    nx1 <= 34'((pr_x + 68'sd536870912) >>> 30);
    nz1 <= 34'((pr_z + 68'sd536870912) >>> 30);
    ct1 <= ct;
    // radius products
    nx2 <= nx1; nz2 <= nz1; ct2 <= ct1;
    px2 <= nx1 * $signed({1'b0, s1.radius});
    py2 <= ct1 * $signed({1'b0, s1.radius});
    pz2 <= nz1 * $signed({1'b0, s1.radius});
    // output registers
    pos_x          <= pos_x_next;
    pos_y          <= pos_y_next;
    pos_z          <= pos_z_next;
    norm_x         <= norm_x_next;
    norm_y         <= norm_y_next;
    norm_z         <= norm_z_next;
    tex_u          <= tex_u_next;
    tex_v          <= tex_v_next;
    vertex_address <= addr_next;
    out_of_range   <= oor_next;
    if (rst) begin
      s1   <= '0;
      s2   <= '0;
      done <= 1'b0;
    end else begin
      s1   <= s_in;
      s2   <= s1;
      done <= s2.vld;
    end
  end

  // a beat leaving the back end entered it and passed through s1, s2 and the done register
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s_in.vld, 3)) else $error("done without entry");
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> (pos_y == '0 && vertex_address == '0))
    else $error("out of range not cleared");
  a_pole_norm: assert property (@(posedge clk) disable iff (rst)
    (done && tex_v == 16'd32768) |-> (norm_y == 16'sd16384))
    else $error("north pole normal");

endmodule

/* sv/uv_sphere_vertex_generator_top.sv */
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_top: UV sphere vertex generator
// Gives position, normal, texture and address of one sphere grid point.
// ----------------------------------------------------------------------------
// Use: raise start with grid_row/grid_col; a beat is taken whenever start is
// high and busy is low. busy is always low, so one point per cycle is taken.
// The result is on the ports for exactly one cycle, marked by done; the receiver
// cannot stall and results are never held. On its way it passes the setup
// register (loaded at the accepting edge), one register per CORDIC rotation
// cell and three product/rounding registers.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 latitude
// level, 1 longitude level, 2 sphere radius) at once; write only while no
// beat is in flight.
// Reset: synchronous rst clears the pipeline valids and sets both levels to 2
// and the radius to 256.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_top #(
  parameter int CORDIC_STAGES = uvs_pkg::CORDIC_STAGES_DEF,
  parameter int MAX_LON_LEVEL = uvs_pkg::MAX_LON_LEVEL_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [6:0]         grid_row,
  input  logic [6:0]         grid_col,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [15:0]        tex_u,
  output logic [15:0]        tex_v,
  output logic [13:0]        vertex_address,
  output logic               out_of_range
);

  logic [2:0]  lat_cfg;
  logic [2:0]  lon_cfg;
  logic [15:0] sphere_radius;

  uvs_pkg::rot_t  t_c [CORDIC_STAGES+1];
  uvs_pkg::rot_t  p_c [CORDIC_STAGES+1];
  uvs_pkg::side_t s_c [CORDIC_STAGES+1];

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_cfg       <= 3'd2;
      lon_cfg       <= 3'd2;
      sphere_radius <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        uvs_pkg::REG_LAT:    lat_cfg       <= cfg_data[2:0];
        uvs_pkg::REG_LON:    lon_cfg       <= cfg_data[2:0];
        uvs_pkg::REG_RADIUS: sphere_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  uvs_front #(.MAX_LON_LEVEL(MAX_LON_LEVEL)) u_front (
    .clk(clk), .rst(rst), .go(start && !busy),
    .grid_row(grid_row), .grid_col(grid_col),
    .lat_cfg(lat_cfg), .lon_cfg(lon_cfg), .sphere_radius(sphere_radius),
    .t_out(t_c[0]), .p_out(p_c[0]), .s_out(s_c[0])
  );

  // chain of rotation cells
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    uvs_cell #(.STAGE(k)) u_cell (
      .clk(clk), .rst(rst),
      .t_in(t_c[k]), .p_in(p_c[k]), .s_in(s_c[k]),
      .t_out(t_c[k+1]), .p_out(p_c[k+1]), .s_out(s_c[k+1])
    );
  end

  uvs_back u_back (
    .clk(clk), .rst(rst),
    .t_in(t_c[CORDIC_STAGES]), .p_in(p_c[CORDIC_STAGES]), .s_in(s_c[CORDIC_STAGES]),
    .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .tex_u(tex_u), .tex_v(tex_v), .vertex_address(vertex_address),
    .out_of_range(out_of_range)
  );

endmodule

/* tb/uv_sphere_vertex_generator_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_top_tb: vertex generator regression
// Drives grid points through the command port, predicts each vertex with a
// bit-exact CORDIC model, and compares every done beat against the oldest
// expected vertex. It walks several register settings, including the extremes.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_top_tb;

  localparam int STAGES  = uvs_pkg::CORDIC_STAGES_DEF;
  localparam int MAX_LON = uvs_pkg::MAX_LON_LEVEL_DEF;
  localparam int LATENCY = STAGES + 4;

  typedef struct packed {
    logic [6:0] row;
    logic [6:0] col;
  } point_t;

  typedef struct packed {
    logic signed [16:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [15:0]        u, v;
    logic [13:0]        addr;
    logic               oor;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [6:0] grid_row = '0;
  logic [6:0] grid_col = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = uvs_pkg::REG_LAT;
  logic [15:0] cfg_data = '0;
  logic done;
  logic signed [16:0] pos_x, pos_y, pos_z;
  logic signed [15:0] norm_x, norm_y, norm_z;
  logic [15:0] tex_u, tex_v;
  logic [13:0] vertex_address;
  logic out_of_range;

  point_t  pending_pts[$];
  vertex_t vertex_q[$];
  int      errors = 0;
  int      idle_pct = 0;

  // model copy of the registers
  logic [2:0]  lat_reg = 3'd2;
  logic [2:0]  lon_reg = 3'd2;
  logic [15:0] radius_reg = 16'd256;

  uv_sphere_vertex_generator_top u_top (.*);

  always #5 clk = ~clk;

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // rotation-mode CORDIC on a binary angle, Q2.30 outputs
  task automatic cordic_sincos(input logic [31:0] ang, output longint s,
                               output longint c);
    logic flip;
    logic [31:0] a;
    longint z, x, y, dx, dy;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    a = flip ? ang - 32'h8000_0000 : ang;
    z = longint'(signed'(a));
    x = 652032874;
    y = 0;
    for (int k = 0; k < STAGES && k < uvs_pkg::ATAN_ENTRIES; k++) begin
      dx = floor_shr(y, k);
      dy = floor_shr(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(uvs_pkg::atan_turn(k));
      end else begin
        x += dx; y -= dy; z += longint'(uvs_pkg::atan_turn(k));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint q30_mul(longint a, longint b);
    return floor_shr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic longint scale_pos(longint v, longint r);
    return clip(floor_shr(v * r + (64'sd1 <<< 29), 30), 65535);
  endfunction

  function automatic longint scale_norm(longint v);
    return clip(floor_shr(v + (64'sd1 <<< 15), 16), 16384);
  endfunction

  // expected vertex for one grid point under the current registers
  task automatic predict_vertex(input point_t p, output vertex_t e);
    longint lat, lon, rings, cols, row, col, r, den, st, ct, sp, cp, nx, nz;
    logic [31:0] theta, phi;
    lat = (lat_reg < 3'd1) ? 1 : ((lat_reg > 3'd6) ? 6 : longint'(lat_reg));
    lon = (longint'(lon_reg) > MAX_LON) ? MAX_LON : longint'(lon_reg);
    rings = 3 * (1 << (lat - 1)) - 1;
    cols = 1 << (lon + 1);
    row = longint'(p.row);
    col = longint'(p.col);
    r = longint'(radius_reg);
    e = '0;
    if (row > rings + 1 || col >= cols) begin
      e.oor = 1'b1;
    end else begin
      e.u = 16'(((col + 1) << 15) >> (lon + 1));
      e.addr = 14'(row * cols + col);
      if (row == 0) begin
        e.py = 17'(r); e.ny = 16'sd16384; e.v = 16'd32768;
      end else if (row == rings + 1) begin
        e.py = 17'(-r); e.ny = -16'sd16384; e.v = 16'd0;
      end else begin
        den = rings + 1;
        theta = 32'(((row << (32 - lat)) + 1) / 3);
        phi = 32'((col + 1) << (32 - (lon + 1)));
        cordic_sincos(theta, st, ct);
        cordic_sincos(phi, sp, cp);
        nx = q30_mul(st, cp);
        nz = q30_mul(st, sp);
        e.px = 17'(scale_pos(nx, r));
        e.py = 17'(scale_pos(ct, r));
        e.pz = 17'(scale_pos(nz, r));
        e.nx = 16'(scale_norm(nx));
        e.ny = 16'(scale_norm(ct));
        e.nz = 16'(scale_norm(nz));
        e.v = 16'((row * 65536 + den) / (2 * den));
      end
    end
  endtask

  // queue one grid point for the driver
  task automatic add_point(input point_t p);
    pending_pts = {pending_pts, p};
  endtask

  // driver: one beat per accepted start, random idle cycles
  always @(posedge clk) begin
    vertex_t e;
    if (!rst) begin
      if (start && !busy) begin
        predict_vertex(point_t'({grid_row, grid_col}), e);
        vertex_q = {vertex_q, e};
        void'(pending_pts.pop_front());
      end
      if (pending_pts.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        grid_row <= pending_pts[0].row;
        grid_col <= pending_pts[0].col;
      end else if (!(start && busy)) begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each done beat with the oldest expectation
  always @(posedge clk) begin
    vertex_t e;
    if (!rst && done) begin
      if (vertex_q.size() == 0) begin
        $error("unexpected vertex beat");
        errors++;
      end else begin
        e = vertex_q.pop_front();
        if (pos_x !== e.px) begin $error("pos_x exp %0d got %0d", e.px, pos_x); errors++; end
        if (pos_y !== e.py) begin $error("pos_y exp %0d got %0d", e.py, pos_y); errors++; end
        if (pos_z !== e.pz) begin $error("pos_z exp %0d got %0d", e.pz, pos_z); errors++; end
        if (norm_x !== e.nx) begin $error("norm_x exp %0d got %0d", e.nx, norm_x); errors++; end
        if (norm_y !== e.ny) begin $error("norm_y exp %0d got %0d", e.ny, norm_y); errors++; end
        if (norm_z !== e.nz) begin $error("norm_z exp %0d got %0d", e.nz, norm_z); errors++; end
        if (tex_u !== e.u) begin $error("tex_u exp %0d got %0d", e.u, tex_u); errors++; end
        if (tex_v !== e.v) begin $error("tex_v exp %0d got %0d", e.v, tex_v); errors++; end
        if (vertex_address !== e.addr) begin
          $error("vertex_address exp %0d got %0d", e.addr, vertex_address); errors++;
        end
        if (out_of_range !== e.oor) begin
          $error("out_of_range exp %0d got %0d", e.oor, out_of_range); errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      uvs_pkg::REG_LAT:    lat_reg = val[2:0];
      uvs_pkg::REG_LON:    lon_reg = val[2:0];
      uvs_pkg::REG_RADIUS: radius_reg = val;
      default: ;
    endcase
  endtask

  // wait for the pipe to drain before touching registers
  task automatic drain();
    while (pending_pts.size() != 0 || start || vertex_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // mostly in-grid points with random content, some out of range
  task automatic random_points(input int n);
    int lat, lon, rows, cols;
    point_t p;
    lat = (lat_reg < 3'd1) ? 1 : ((lat_reg > 3'd6) ? 6 : int'(lat_reg));
    lon = (int'(lon_reg) > MAX_LON) ? MAX_LON : int'(lon_reg);
    rows = 3 * (1 << (lat - 1)) + 1;
    cols = 1 << (lon + 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) begin
        p.row = 7'($urandom_range(rows - 1));
        p.col = 7'($urandom_range(cols - 1));
      end else begin
        p.row = 7'($urandom);
        p.col = 7'($urandom);
      end
      add_point(p);
    end
  endtask

  initial begin
    logic [15:0] radii[5];
    logic [2:0]  lats[5];
    logic [2:0]  lons[5];
    radii = '{16'd1, 16'd65535, 16'd256, 16'd40000, 16'd300};
    lats  = '{3'd1, 3'd6, 3'd0, 3'd7, 3'd3};
    lons  = '{3'd0, 3'd6, 3'd7, 3'd2, 3'd4};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // directed: poles, first ring, last column, extremes, out of range
    add_point('{7'd0, 7'd0});
    add_point('{7'd6, 7'd7});
    add_point('{7'd1, 7'd0});
    add_point('{7'd3, 7'd3});
    add_point('{7'd5, 7'd6});
    add_point('{7'd7, 7'd0});
    add_point('{7'd0, 7'd8});
    add_point('{7'd127, 7'd127});
    add_point('{7'd2, 7'd1});
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(uvs_pkg::REG_LAT, {13'd0, lats[ph]});
      write_reg(uvs_pkg::REG_LON, {13'd0, lons[ph]});
      write_reg(uvs_pkg::REG_RADIUS, radii[ph]);
      idle_pct = (ph == 1) ? 62 : (ph == 3 ? 36 : 0);
      add_point('{7'd0, 7'd0});
      add_point('{7'd1, 7'd127});
      random_points(100);
      drain();
    end
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
